@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers. They expect clk and arst_n in the enclosing scope.

`define FDF_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

`define FDF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ sv/fdf_pkg.sv @@
`timescale 1ns / 1ps

package fdf_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam logic KIND_INTERIOR = 1'b0;
	localparam logic KIND_BOUNDARY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic        [30:0] diffusivity;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
		logic signed [31:0] value_difference;
		logic signed [31:0] grad_sum_x;
		logic signed [31:0] grad_sum_y;
		logic signed [31:0] grad_sum_z;
	} fdf_in_t;

	typedef struct packed {
		logic signed [31:0] flux;
		logic        [30:0] conductance;
		logic               error;
	} fdf_out_t;

	// Per-face data that rides alongside the divider.
	typedef struct packed {
		logic               kind;
		logic        [30:0] d;
		logic signed [31:0] dphi;
		logic signed [31:0] gn;
		logic signed [31:0] gs;
		logic               err;
		logic               zd;
	} fdf_side_t;

	typedef struct packed {
		logic [31:0] ua;
		logic [31:0] ub;
		logic        neg;
	} fdf_divop_t;

	// Round to nearest, ties toward plus infinity, then shift right by k.
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
			input int k);
		logic signed [63:0] half;
		half = 64'sd1 <<< (k - 1);
		return (v + half) >>> k;
	endfunction

	function automatic logic sat_ovf(input logic signed [63:0] v);
		return (v > 64'sd2147483647) || (v < -64'sd2147483648);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		return a[31] ? (~a + 32'd1) : a;
	endfunction

endpackage

@@ sv/face_diffusive_flux_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Diffusive flux of a finite-volume scalar across one face, Q16.16 by default.
// Input channel: in_valid/in_stall carry one face per beat in in_item.
// Output channel: out_valid/out_stall carry flux, conductance and error in out_item.
// cfg_we writes cfg_wdata into the implicit-enable bit; write it only while idle.
// A face can be taken on every cycle that in_stall is low; throughput is one
// beat per clock while no output beat is held. Faces pass the dot stages, the
// 33-stage quotient pipeline (one quotient bit per stage) and the post stages.
// The whole pipeline advances together; while an output beat is held by
// out_stall every stage holds. A one-entry input buffer takes the beat offered
// while the pipeline holds, so in_stall is a register and rises in the cycle
// after it takes a beat. Reset clears all valid bits, empties the input buffer and
// turns implicit mode off; no beat is lost or repeated across a stall.
module face_diffusive_flux_core import fdf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  fdf_in_t  in_item,
	output logic     out_valid,
	input  logic     out_stall,
	output fdf_out_t out_item,
	input  logic     cfg_we,
	input  logic     cfg_wdata
);

	logic       implicit_enable_q;
	logic       skid_valid_q;
	fdf_in_t    skid_q;
	logic       adv;
	logic       p_valid;
	fdf_in_t    p_item;

	logic       dot_v;
	fdf_side_t  dot_side;
	fdf_divop_t dot_op;

	logic               div_v;
	logic signed [31:0] div_q;
	logic               div_ovf;
	fdf_side_t          div_side;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = skid_valid_q;
	assign p_valid  = skid_valid_q | in_valid;
	assign p_item   = skid_valid_q ? skid_q : in_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			implicit_enable_q <= 1'b0;
		end else if (cfg_we) begin
			implicit_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (adv) begin
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && in_valid && !skid_valid_q)
			skid_q <= in_item;
	end

	fdf_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (p_valid),
		.item   (p_item),
		.v_out  (dot_v),
		.side   (dot_side),
		.op     (dot_op)
	);

	fdf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_in     (dot_v),
		.op       (dot_op),
		.side_in  (dot_side),
		.v_out    (div_v),
		.quot     (div_q),
		.quot_ovf (div_ovf),
		.side_out (div_side)
	);

	fdf_post #(.FRAC_BITS(FRAC_BITS)) u_post (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.implicit_enable (implicit_enable_q),
		.v_in            (div_v),
		.c               (div_q),
		.c_ovf           (div_ovf),
		.side            (div_side),
		.v_out           (out_valid),
		.result          (out_item)
	);

	`FDF_ASSERT_IMPLIES(a_cond_off, out_valid && !implicit_enable_q, out_item.conductance == 31'd0)
	`FDF_ASSERT_NEXT(a_skid_hold, skid_valid_q && !adv, skid_valid_q)
	`FDF_ASSERT_NEXT(a_skid_drain, skid_valid_q && adv, !skid_valid_q)

endmodule

@@ sv/fdf_dot.sv @@
`timescale 1ns / 1ps

module fdf_dot import fdf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       v_in,
	input  fdf_in_t    item,
	output logic       v_out,
	output fdf_side_t  side,
	output fdf_divop_t op
);

	logic signed [31:0] nv [3];
	logic signed [31:0] sv [3];
	logic signed [31:0] gv [3];
	logic signed [63:0] prod [4][3];

	logic signed [63:0] p_s1 [4][3];
	logic               kind_s1;
	logic        [30:0] d_s1;
	logic signed [31:0] dphi_s1;
	logic               v_s1;

	logic signed [63:0] sum_s2 [4];
	logic               kind_s2;
	logic        [30:0] d_s2;
	logic signed [31:0] dphi_s2;
	logic               v_s2;

	fdf_side_t          side_s3;
	fdf_divop_t         op_s3;
	logic               v_s3;

	logic signed [31:0] dt [4];
	logic               dov [4];
	fdf_side_t          side_nx;
	fdf_divop_t         op_nx;

	assign nv[0] = item.normal_x;
	assign nv[1] = item.normal_y;
	assign nv[2] = item.normal_z;
	assign sv[0] = item.offset_x;
	assign sv[1] = item.offset_y;
	assign sv[2] = item.offset_z;
	assign gv[0] = item.grad_sum_x;
	assign gv[1] = item.grad_sum_y;
	assign gv[2] = item.grad_sum_z;

	// Slot 0 holds S.S on interior faces and N.N on boundary faces.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[0][i] = (item.kind == KIND_BOUNDARY) ? nv[i] * nv[i] : sv[i] * sv[i];
			prod[1][i] = nv[i] * sv[i];
			prod[2][i] = gv[i] * nv[i];
			prod[3][i] = gv[i] * sv[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1    <= prod;
			kind_s1 <= item.kind;
			d_s1    <= item.diffusivity;
			dphi_s1 <= item.value_difference;
			for (int k = 0; k < 4; k++) begin
				sum_s2[k] <= rnd_shift(p_s1[k][0], FRAC_BITS)
					+ rnd_shift(p_s1[k][1], FRAC_BITS)
					+ rnd_shift(p_s1[k][2], FRAC_BITS);
			end
			kind_s2 <= kind_s1;
			d_s2    <= d_s1;
			dphi_s2 <= dphi_s1;
			side_s3 <= side_nx;
			op_s3   <= op_nx;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dt[k]  = sat32(sum_s2[k]);
			dov[k] = sat_ovf(sum_s2[k]);
		end
		side_nx.kind = kind_s2;
		side_nx.d    = d_s2;
		side_nx.dphi = dphi_s2;
		side_nx.gn   = dt[2];
		side_nx.gs   = dt[3];
		if (kind_s2 == KIND_BOUNDARY) begin
			side_nx.err = dov[0] | dov[1];
			side_nx.zd  = (dt[1] == 32'sd0);
			op_nx.ua    = mag32(dt[0]);
			op_nx.ub    = mag32(dt[1]);
			op_nx.neg   = dt[0][31];
		end else begin
			side_nx.err = dov[0] | dov[1] | dov[2] | dov[3];
			side_nx.zd  = (dt[0] == 32'sd0);
			op_nx.ua    = mag32(dt[1]);
			op_nx.ub    = mag32(dt[0]);
			op_nx.neg   = dt[1][31] ^ dt[0][31];
		end
	end

	assign v_out = v_s3;
	assign side  = side_s3;
	assign op    = op_s3;

endmodule

@@ sv/fdf_div.sv @@
`timescale 1ns / 1ps

module fdf_div import fdf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               v_in,
	input  fdf_divop_t         op,
	input  fdf_side_t          side_in,
	output logic               v_out,
	output logic signed [31:0] quot,
	output logic               quot_ovf,
	output fdf_side_t          side_out
);

	localparam int QB = 33;
	localparam int NW = 33 + FRAC_BITS;
	localparam int RW = 66;

	logic [NW-1:0] num;
	logic          ovf_pre;

	logic [RW-1:0] rem_s  [QB+1];
	logic [QB-1:0] q_s    [QB+1];
	logic [31:0]   ub_s   [QB+1];
	logic          neg_s  [QB+1];
	logic          ovf_s  [QB+1];
	logic          v_s    [QB+1];
	fdf_side_t     side_s [QB+1];

	logic signed [31:0] quot_sf;
	logic               ovf_sf;
	logic               v_sf;
	fdf_side_t          side_sf;

	logic               cov;
	logic signed [31:0] cval;

	// The rounding bias depends on the sign of the quotient.
	always_comb begin
		num = (NW'(op.ua) << FRAC_BITS)
			+ NW'(op.neg ? ((op.ub - 32'd1) >> 1) : (op.ub >> 1));
		ovf_pre = RW'(num >> QB) >= RW'(op.ub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (adv)
			v_s[0] <= v_in;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= RW'(num);
			q_s[0]    <= '0;
			ub_s[0]   <= op.ub;
			neg_s[0]  <= op.neg;
			ovf_s[0]  <= ovf_pre;
			side_s[0] <= side_in;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 1; j <= QB; j++) begin : g_stage
		localparam int BI = QB - j;
		logic [RW-1:0] sh;
		logic          take;

		assign sh   = RW'(ub_s[j-1]) << BI;
		assign take = rem_s[j-1] >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[j] <= 1'b0;
			else if (adv)
				v_s[j] <= v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j]  <= take ? rem_s[j-1] - sh : rem_s[j-1];
				q_s[j]    <= take ? (q_s[j-1] | (QB'(1) << BI)) : q_s[j-1];
				ub_s[j]   <= ub_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				ovf_s[j]  <= ovf_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	always_comb begin
		if (neg_s[QB])
			cov = ovf_s[QB] || (q_s[QB] > 33'h080000000);
		else
			cov = ovf_s[QB] || (q_s[QB] > 33'h07fffffff);
		if (cov)
			cval = neg_s[QB] ? 32'sh80000000 : 32'sh7fffffff;
		else
			cval = neg_s[QB] ? -q_s[QB][31:0] : q_s[QB][31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sf <= 1'b0;
		else if (adv)
			v_sf <= v_s[QB];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quot_sf <= cval;
			ovf_sf  <= cov;
			side_sf <= side_s[QB];
		end
	end

	assign v_out    = v_sf;
	assign quot     = quot_sf;
	assign quot_ovf = ovf_sf;
	assign side_out = side_sf;

endmodule

@@ sv/fdf_post.sv @@
`timescale 1ns / 1ps

module fdf_post import fdf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               implicit_enable,
	input  logic               v_in,
	input  logic signed [31:0] c,
	input  logic               c_ovf,
	input  fdf_side_t          side,
	output logic               v_out,
	output fdf_out_t           result
);

	logic signed [31:0] d32;
	fdf_side_t          side_m;

	// Stage 1: products with the coefficient.
	logic signed [63:0] pa_s1, pb_s1, pc_s1;
	fdf_side_t          side_s1;
	logic               v_s1;

	// Stage 2: rounded and saturated products, and the saturated correction term.
	logic signed [31:0] corr_s2, t2_s2, g_s2;
	logic               kind_s2, err_s2, cerr_s2, zd_s2;
	logic        [30:0] d_s2;
	logic signed [31:0] dphi_s2;
	logic               v_s2;

	// Stage 3: multiplier operands for the flux.
	logic signed [31:0] x_s3, y_s3, g_s3;
	logic               err_s3, cerr_s3, zd_s3;
	logic               v_s3;

	// Stage 4: flux product.
	logic signed [63:0] pf_s4;
	logic signed [31:0] g_s4;
	logic               err_s4, cerr_s4, zd_s4;
	logic               v_s4;

	fdf_out_t           res_s5;
	logic               v_s5;

	logic signed [31:0] t1, t2, gr;
	logic               t1_ov, t2_ov, g_ov;
	logic signed [63:0] diff, inner;
	logic               corr_ov, inner_ov;
	logic signed [31:0] inner_sat;
	logic signed [63:0] fr;
	logic signed [31:0] flux_nx;
	logic               flux_ov;
	fdf_out_t           res_nx;
	logic               gneg, ce;

	assign d32 = {1'b0, side.d};

	// A saturated coefficient joins the error flags carried with the face.
	always_comb begin
		side_m     = side;
		side_m.err = side.err | c_ovf;
	end

	always_comb begin
		t1      = sat32(rnd_shift(pa_s1, FRAC_BITS));
		t1_ov   = sat_ovf(rnd_shift(pa_s1, FRAC_BITS));
		t2      = sat32(rnd_shift(pb_s1, FRAC_BITS));
		t2_ov   = sat_ovf(rnd_shift(pb_s1, FRAC_BITS));
		gr      = sat32(rnd_shift(pc_s1, FRAC_BITS));
		g_ov    = sat_ovf(rnd_shift(pc_s1, FRAC_BITS));
		diff    = 64'(side_s1.gn) - 64'(t1);
		corr_ov = sat_ovf(diff);
	end

	always_comb begin
		inner     = 64'(t2_s2) + rnd_shift(64'(corr_s2), 1);
		inner_ov  = sat_ovf(inner);
		inner_sat = sat32(inner);
	end

	always_comb begin
		fr      = rnd_shift(pf_s4, FRAC_BITS);
		flux_nx = sat32(fr);
		flux_ov = sat_ovf(fr);
		gneg    = g_s4[31];
		ce      = (cerr_s4 | gneg) & implicit_enable;
		res_nx.flux        = flux_nx;
		res_nx.conductance = (gneg || !implicit_enable) ? 31'd0 : g_s4[30:0];
		res_nx.error       = err_s4 | flux_ov | ce;
		if (zd_s4) begin
			res_nx.flux        = 32'sd0;
			res_nx.conductance = 31'd0;
			res_nx.error       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1       <= c * side.gs;
			pb_s1       <= c * side.dphi;
			pc_s1       <= d32 * c;
			side_s1     <= side_m;

			kind_s2 <= side_s1.kind;
			d_s2    <= side_s1.d;
			dphi_s2 <= side_s1.dphi;
			zd_s2   <= side_s1.zd;
			corr_s2 <= sat32(diff);
			t2_s2   <= t2;
			g_s2    <= gr;
			if (side_s1.kind == KIND_BOUNDARY) begin
				err_s2  <= side_s1.err | g_ov;
				cerr_s2 <= 1'b0;
			end else begin
				err_s2  <= side_s1.err | t1_ov | corr_ov | t2_ov;
				cerr_s2 <= g_ov;
			end

			if (kind_s2 == KIND_BOUNDARY) begin
				x_s3   <= g_s2;
				y_s3   <= dphi_s2;
				err_s3 <= err_s2;
			end else begin
				x_s3   <= {1'b0, d_s2};
				y_s3   <= inner_sat;
				err_s3 <= err_s2 | inner_ov;
			end
			g_s3    <= g_s2;
			cerr_s3 <= cerr_s2;
			zd_s3   <= zd_s2;

			pf_s4   <= x_s3 * y_s3;
			g_s4    <= g_s3;
			err_s4  <= err_s3;
			cerr_s4 <= cerr_s3;
			zd_s4   <= zd_s3;

			res_s5 <= res_nx;
		end
	end

	assign v_out  = v_s5;
	assign result = res_s5;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import fdf_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int N_RANDOM = 1600;

	typedef struct {
		fdf_in_t  face;
		bit       typed;
		fdf_out_t result;
	} face_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	fdf_in_t  in_item = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	fdf_out_t out_item;
	logic     cfg_we = 1'b0;
	logic     cfg_wdata = 1'b0;

	bit       implicit_on = 1'b0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       fail_count = 0;
	int       quiet_cycles = 0;
	fdf_out_t flux_expect_q[$];
	face_row_t face_table[$];

	always #10 clk = ~clk;

	face_diffusive_flux_core #(.FRAC_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	function automatic logic signed [63:0] round_shr(logic signed [63:0] v, int k);
		return (v + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic logic signed [63:0] clamp32(logic signed [63:0] v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
		return round_shr(a * b, FB);
	endfunction

	// Quotient rounded to nearest on the magnitude, ties toward plus infinity.
	function automatic logic signed [63:0] fx_div(logic signed [63:0] a, logic signed [63:0] b);
		bit neg;
		longint unsigned ua, ub, num, q;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		num = (ua << FB) + (neg ? (ub - 1) / 2 : ub / 2);
		q = num / ub;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [63:0] fx_dot(logic signed [63:0] ax, logic signed [63:0] ay,
			logic signed [63:0] az, logic signed [63:0] bx, logic signed [63:0] by,
			logic signed [63:0] bz, inout bit ovf);
		return clamp32(fx_mul(ax, bx) + fx_mul(ay, by) + fx_mul(az, bz), ovf);
	endfunction

	function automatic fdf_out_t face_flux_predict(fdf_in_t f, bit implicit);
		fdf_out_t r;
		bit err, cerr;
		logic signed [63:0] nx, ny, nz, sx, sy, sz, gx, gy, gz, d, dphi;
		logic signed [63:0] ss, ns, nn, c, gn, gs, corr, inner, flux, g;
		err = 1'b0;
		cerr = 1'b0;
		nx = f.normal_x; ny = f.normal_y; nz = f.normal_z;
		sx = f.offset_x; sy = f.offset_y; sz = f.offset_z;
		gx = f.grad_sum_x; gy = f.grad_sum_y; gz = f.grad_sum_z;
		d = {33'd0, f.diffusivity};
		dphi = f.value_difference;
		r = '{flux: '0, conductance: '0, error: 1'b1};
		if (f.kind == KIND_INTERIOR) begin
			ss = fx_dot(sx, sy, sz, sx, sy, sz, err);
			if (ss == 0)
				return r;
			ns = fx_dot(nx, ny, nz, sx, sy, sz, err);
			c = clamp32(fx_div(ns, ss), err);
			gn = fx_dot(gx, gy, gz, nx, ny, nz, err);
			gs = fx_dot(gx, gy, gz, sx, sy, sz, err);
			corr = clamp32(gn - clamp32(fx_mul(c, gs), err), err);
			inner = clamp32(clamp32(fx_mul(c, dphi), err) + round_shr(corr, 1), err);
			flux = clamp32(fx_mul(d, inner), err);
			g = clamp32(fx_mul(d, c), cerr);
		end else begin
			ns = fx_dot(nx, ny, nz, sx, sy, sz, err);
			if (ns == 0)
				return r;
			nn = fx_dot(nx, ny, nz, nx, ny, nz, err);
			c = clamp32(fx_div(nn, (ns < 0) ? -ns : ns), err);
			g = clamp32(fx_mul(d, c), err);
			flux = clamp32(fx_mul(g, dphi), err);
		end
		if (g < 0) begin
			g = 0;
			cerr = 1'b1;
		end
		if (!implicit) begin
			g = 0;
			cerr = 1'b0;
		end
		r.flux = flux[31:0];
		r.conductance = g[30:0];
		r.error = err | cerr;
		return r;
	endfunction

	function automatic fdf_in_t make_face(logic kind, logic [30:0] d,
			logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
			logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic [31:0] dp,
			logic [31:0] gx, logic [31:0] gy, logic [31:0] gz);
		return '{kind, d, nx, ny, nz, sx, sy, sz, dp, gx, gy, gz};
	endfunction

	// Mostly moderate magnitudes so that results stay in range; some full width.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom) >>> $urandom_range(24, 8));
			2: return 32'($signed($urandom) >>> 12);
			default: return 32'($signed($urandom) >>> 16);
		endcase
	endfunction

	function automatic fdf_in_t rand_face();
		fdf_in_t f;
		f = make_face($urandom_range(1), 31'($urandom) >> $urandom_range(20),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word());
		if ($urandom_range(49) == 0) begin
			f.offset_x = '0;
			f.offset_y = '0;
			f.offset_z = '0;
		end
		return f;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic send_face(fdf_in_t f, bit typed, fdf_out_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item <= f;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		flux_expect_q.push_back(typed ? want : face_flux_predict(f, implicit_on));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (flux_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_implicit(bit v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		implicit_on = v;
	endtask

	always @(posedge clk) begin
		fdf_out_t want;
		if (out_valid && !out_stall) begin
			if (flux_expect_q.size() == 0) begin
				report_mismatch("unexpected beat", out_item, '0);
			end else begin
				want = flux_expect_q.pop_front();
				if (out_item.flux !== want.flux)
					report_mismatch("flux", out_item.flux, want.flux);
				if (out_item.conductance !== want.conductance)
					report_mismatch("conductance", out_item.conductance, want.conductance);
				if (out_item.error !== want.error)
					report_mismatch("error", out_item.error, want.error);
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		fdf_out_t none;
		none = '0;
		// Zero S.S, zero N.S and unit orthogonal face have results known by hand.
		face_table.push_back('{make_face(KIND_INTERIOR, 31'h7fffffff, 32'h10000, 0, 0,
			0, 0, 0, 32'h10000, 0, 0, 0), 1'b1, '{0, 0, 1'b1}});
		face_table.push_back('{make_face(KIND_BOUNDARY, 31'h10000, 32'h10000, 0, 0,
			0, 32'h10000, 0, 32'h10000, 0, 0, 0), 1'b1, '{0, 0, 1'b1}});
		face_table.push_back('{make_face(KIND_INTERIOR, 31'h10000, 32'h10000, 0, 0,
			32'h10000, 0, 0, 32'h10000, 0, 0, 0), 1'b1, '{32'h10000, 0, 1'b0}});
		face_table.push_back('{make_face(KIND_BOUNDARY, 31'h10000, 32'h10000, 0, 0,
			32'h8000, 0, 0, 32'h10000, 0, 0, 0), 1'b0, none});
		face_table.push_back('{make_face(KIND_INTERIOR, 31'h20000, 32'h10000, 32'h8000, 0,
			32'hffff0000, 0, 0, 32'h30000, 32'h10000, 32'h20000, 32'hfffe0000),
			1'b0, none});
		face_table.push_back('{make_face(KIND_INTERIOR, 31'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff), 1'b0, none});
		face_table.push_back('{make_face(KIND_BOUNDARY, 31'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff), 1'b0, none});
		face_table.push_back('{make_face(KIND_INTERIOR, 0, 32'h10000, 32'h10000, 32'h10000,
			32'h1, 0, 0, 32'h80000000, 32'h7fffffff, 0, 0), 1'b0, none});
		face_table.push_back('{make_face(KIND_BOUNDARY, 31'h1, 32'h1, 0, 0,
			32'h100, 0, 0, 32'h80000000, 0, 0, 0), 1'b0, none});
		face_table.push_back('{make_face(KIND_INTERIOR, 31'h18000, 32'h4000, 32'hffffc000,
			32'h2000, 32'h8000, 32'h4000, 32'hffff8000, 32'hfff00000, 32'h50000,
			32'hfffb0000, 32'h0), 1'b0, none});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 6;
		recv_stall_pct = 69;
		foreach (face_table[i])
			send_face(face_table[i].face, face_table[i].typed, face_table[i].result);

		write_implicit(1'b1);
		foreach (face_table[i])
			send_face(face_table[i].face, 1'b0, none);
		for (int n = 0; n < N_RANDOM / 3; n++)
			send_face(rand_face(), 1'b0, none);

		write_implicit(1'b0);
		send_idle_pct = 69;
		recv_stall_pct = 6;
		for (int n = 0; n < N_RANDOM / 3; n++) begin
			// Hold the input off once until the pipeline has emptied.
			if (n == N_RANDOM / 6) begin
				in_valid <= 1'b0;
				while (flux_expect_q.size() != 0)
					@(posedge clk);
			end
			send_face(rand_face(), 1'b0, none);
		end

		write_implicit(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int n = 0; n < N_RANDOM / 3; n++)
			send_face(rand_face(), 1'b0, none);

		wait_drained();
		if (fail_count == 0 && flux_expect_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
